>>> design/csmamac_pkg.sv
`timescale 1ns / 1ps

package csmamac_pkg;

  localparam int QUEUE_DEPTH_DEF = 8;

  localparam int ADDR_W = 48;
  localparam int TAG_W = 16;
  localparam int DRAW_W = 4;
  localparam int COUNT_W = 4;
  localparam int CFG_IDX_W = 1;

  localparam logic [DRAW_W-1:0] MAX_DRAW = DRAW_W'(10);
  localparam logic [ADDR_W-1:0] BCAST_ADDR = '1;

  typedef enum logic [1:0] {
    OP_UPPER,
    OP_TICK,
    OP_RADIO,
    OP_RX
  } op_e;

  typedef enum logic [1:0] {
    RADIO_IDLE,
    RADIO_RECEIVE,
    RADIO_TRANSMIT,
    RADIO_SLEEP
  } radio_e;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_SENT,
    ACT_QUEUED,
    ACT_DROPPED,
    ACT_BACKOFF,
    ACT_UP,
    ACT_DISCARD
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STATION_ADDR,
    CFG_QUEUE_LIMIT
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]        op;
    logic [TAG_W-1:0]  packet_tag;
    logic [ADDR_W-1:0] dest_address;
    logic [1:0]        new_radio_state;
    logic [DRAW_W-1:0] backoff_draw;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         action;
    logic [TAG_W-1:0]   out_tag;
    logic [ADDR_W-1:0]  out_dest;
    logic [COUNT_W-1:0] queued_count;
    logic               backoff_pending;
  } out_item_t;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [ADDR_W-1:0] dest;
  } packet_t;

  typedef struct packed {
    logic push;
    logic pop;
  } qctl_t;

endpackage

>>> design/csma_tx_queue_backoff_mac.sv
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_stall  | in_data (in_item_t)
// out     | output    | out_valid/out_stall| out_data (out_item_t)
// cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One transaction per cycle while in_stall is low: an item is registered in the input
// register, is resolved against the state and is then registered in the result register
// or, when that register still holds an unaccepted result, in the skid entry.
// A two-entry result buffer (result register plus skid) lets input flow on
// while one result is stalled; in_stall rises only once both entries are full.
// Reset is synchronous and clears control state; the queue entries and the held
// packet carry no reset. Configuration is always ready.
`timescale 1ns / 1ps

module csma_tx_queue_backoff_mac #(
  parameter int QUEUE_DEPTH = csmamac_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  csmamac_pkg::in_item_t                 in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output csmamac_pkg::out_item_t                out_data,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [csmamac_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [csmamac_pkg::ADDR_W-1:0]        cfg_data
);
  import csmamac_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [ADDR_W-1:0]  station_address;
  logic [COUNT_W-1:0] queue_limit;

  in_item_t item;
  logic     item_valid;
  logic     go;
  logic     accept;

  out_item_t skid_data;
  logic      skid_valid;
  logic      pop_out;

  logic              backoff_active;
  logic              backoff_active_next;
  logic [DRAW_W-1:0] backoff_left;
  logic [DRAW_W-1:0] backoff_left_next;
  radio_e            radio_now;
  radio_e            radio_now_next;
  logic              sent_tick;
  logic              sent_tick_next;
  packet_t           held_packet;
  packet_t           held_packet_next;

  qctl_t             qctl;
  packet_t           q_head;
  logic [CNT_W-1:0]  q_count;
  logic [CNT_W-1:0]  q_count_after;

  packet_t   item_pkt;
  packet_t   res_pkt;
  action_e   act;
  out_item_t res;

  assign cfg_ready = 1'b1;
  assign in_stall  = item_valid && skid_valid;
  assign accept    = in_valid && !in_stall;
  assign go        = item_valid && !skid_valid;
  assign pop_out   = out_valid && !out_stall;
  assign item_pkt  = '{tag: item.packet_tag, dest: item.dest_address};

  csmamac_txq #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_txq (
    .clk      (clk),
    .rst      (rst),
    .ctl      (qctl),
    .wr_pkt   (res_pkt),
    .head_pkt (q_head),
    .count    (q_count)
  );

  always_comb begin
    logic              offer_en;
    logic              busy;
    logic              can_push;
    logic [DRAW_W-1:0] draw_c;
    packet_t           offer_pkt;

    offer_en  = 1'b0;
    busy      = 1'b0;
    offer_pkt = item_pkt;
    draw_c    = (item.backoff_draw > MAX_DRAW) ? MAX_DRAW : item.backoff_draw;
    can_push  = (int'(q_count) < int'(queue_limit)) && (int'(q_count) < QUEUE_DEPTH);

    act                 = ACT_NONE;
    res_pkt             = '0;
    qctl                = '0;
    backoff_active_next = backoff_active;
    backoff_left_next   = backoff_left;
    radio_now_next      = radio_now;
    sent_tick_next      = sent_tick;
    held_packet_next    = held_packet;

    case (item.op)
      OP_UPPER: begin
        offer_en = 1'b1;
        busy     = backoff_active || (radio_now == RADIO_TRANSMIT) || sent_tick;
      end
      OP_TICK: begin
        sent_tick_next = 1'b0;
        if (backoff_active) begin
          if (backoff_left <= DRAW_W'(1)) begin
            backoff_active_next = 1'b0;
            backoff_left_next   = '0;
            offer_en            = 1'b1;
            offer_pkt           = held_packet;
            busy                = (radio_now == RADIO_TRANSMIT);
          end else begin
            backoff_left_next = backoff_left - DRAW_W'(1);
          end
        end
      end
      OP_RADIO: begin
        radio_now_next = radio_e'(item.new_radio_state);
        if ((radio_e'(item.new_radio_state) == RADIO_IDLE) && (q_count != '0) &&
            !backoff_active) begin
          qctl.pop            = 1'b1;
          held_packet_next    = q_head;
          backoff_left_next   = draw_c;
          backoff_active_next = 1'b1;
          res_pkt             = q_head;
          act                 = ACT_BACKOFF;
        end
      end
      default: begin
        res_pkt = item_pkt;
        act = ((item.dest_address == station_address) || (item.dest_address == BCAST_ADDR)) ?
              ACT_UP : ACT_DISCARD;
      end
    endcase

    if (offer_en) begin
      res_pkt = offer_pkt;
      if (busy) begin
        if (can_push) begin
          qctl.push = 1'b1;
          act       = ACT_QUEUED;
        end else begin
          act = ACT_DROPPED;
        end
      end else if (radio_now == RADIO_IDLE) begin
        sent_tick_next = 1'b1;
        act            = ACT_SENT;
      end else begin
        held_packet_next    = offer_pkt;
        backoff_left_next   = draw_c;
        backoff_active_next = 1'b1;
        act                 = ACT_BACKOFF;
      end
    end

    qctl.push = qctl.push && go;
    qctl.pop  = qctl.pop && go;

    q_count_after = q_count;
    if (qctl.push) begin
      q_count_after = q_count + CNT_W'(1);
    end else if (qctl.pop) begin
      q_count_after = q_count - CNT_W'(1);
    end

    res.action          = act;
    res.out_tag         = (act == ACT_NONE) ? '0 : res_pkt.tag;
    res.out_dest        = (act == ACT_NONE) ? '0 : res_pkt.dest;
    res.queued_count    = COUNT_W'(q_count_after);
    res.backoff_pending = backoff_active_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      station_address <= '0;
      queue_limit     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_STATION_ADDR: station_address <= cfg_data;
        CFG_QUEUE_LIMIT:  queue_limit <= cfg_data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid     <= 1'b0;
      backoff_active <= 1'b0;
      backoff_left   <= '0;
      radio_now      <= RADIO_IDLE;
      sent_tick      <= 1'b0;
    end else begin
      if (accept) begin
        item_valid <= 1'b1;
      end else if (go) begin
        item_valid <= 1'b0;
      end
      if (go) begin
        backoff_active <= backoff_active_next;
        backoff_left   <= backoff_left_next;
        radio_now      <= radio_now_next;
        sent_tick      <= sent_tick_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_data;
    end
    if (go) begin
      held_packet <= held_packet_next;
    end
  end

  // result register with skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop_out) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= go;
      end else begin
        out_valid  <= go;
        skid_valid <= 1'b0;
      end
    end else if (go) begin
      if (!out_valid) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_out) begin
      if (skid_valid) begin
        out_data <= skid_data;
        if (go) begin
          skid_data <= res;
        end
      end else if (go) begin
        out_data <= res;
      end
    end else if (go) begin
      if (!out_valid) begin
        out_data <= res;
      end else begin
        skid_data <= res;
      end
    end
  end

  a_skid_behind_head: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry full with result register empty");

  a_backoff_ends_on_tick: assert property (@(posedge clk) disable iff (rst)
    $fell(backoff_active) |-> ($past(rst) || ($past(go) && ($past(item.op) == OP_TICK))))
    else $error("backoff cleared outside a tick");

  a_sent_flag_source: assert property (@(posedge clk) disable iff (rst)
    $rose(sent_tick) |-> ($past(go) && ($past(radio_now) == RADIO_IDLE)))
    else $error("sent flag set without a send on an idle radio");

endmodule

>>> design/csmamac_txq.sv
`timescale 1ns / 1ps

module csmamac_txq #(
  parameter int QUEUE_DEPTH = csmamac_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  csmamac_pkg::qctl_t                 ctl,
  input  csmamac_pkg::packet_t               wr_pkt,
  output csmamac_pkg::packet_t               head_pkt,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]   count
);
  import csmamac_pkg::*;

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  packet_t mem [QUEUE_DEPTH];

  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] head_next;
  logic [IDX_W-1:0] wr_addr;
  logic [SUM_W-1:0] slot_sum;

  always_comb begin
    slot_sum = SUM_W'(head) + SUM_W'(count);
    if (slot_sum >= SUM_W'(QUEUE_DEPTH)) begin
      slot_sum = slot_sum - SUM_W'(QUEUE_DEPTH);
    end
    wr_addr = IDX_W'(slot_sum);
    head_next = head;
    if (ctl.pop) begin
      head_next = (head == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head + IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      head <= head_next;
      if (ctl.push && !ctl.pop) begin
        count <= count + CNT_W'(1);
      end else if (ctl.pop && !ctl.push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // keep the head entry registered; bypass a write into the next head slot
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[wr_addr] <= wr_pkt;
    end
    if (ctl.push && (wr_addr == head_next)) begin
      head_pkt <= wr_pkt;
    end else begin
      head_pkt <= mem[head_next];
    end
  end

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    ctl.push |-> (int'(count) < QUEUE_DEPTH))
    else $error("push into full transmit queue");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    ctl.pop |-> (count != '0))
    else $error("pop from empty transmit queue");

  a_push_pop_excl: assert property (@(posedge clk) disable iff (rst)
    !(ctl.push && ctl.pop))
    else $error("push and pop in one transaction");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import csmamac_pkg::*;

  localparam int QDEPTH = QUEUE_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 90;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_STATION_ADDR;
  logic [ADDR_W-1:0] cfg_data = '0;

  csma_tx_queue_backoff_mac #(.QUEUE_DEPTH(QDEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // MAC state mirror
  logic [ADDR_W-1:0] m_station = '0;
  logic [COUNT_W-1:0] m_limit = '0;
  packet_t m_qstore [QDEPTH];
  int m_qhead = 0;
  int m_qcount = 0;
  packet_t m_held = '0;
  logic [DRAW_W-1:0] m_bo_left = '0;
  logic m_bo_active = 1'b0;
  radio_e m_radio = RADIO_IDLE;
  logic m_sent_tick = 1'b0;

  in_item_t events_to_send [$];
  out_item_t mac_results_due [$];
  out_item_t want;

  bit send_idle_on = 1'b1;
  bit recv_idle_on = 1'b1;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  int n_results = 0;
  int n_errors = 0;
  int cycle_count = 0;

  function automatic void hold_packet(packet_t p, logic [DRAW_W-1:0] draw);
    m_held = p;
    m_bo_left = (draw > MAX_DRAW) ? MAX_DRAW : draw;
    m_bo_active = 1'b1;
  endfunction

  function automatic action_e offer_packet(packet_t p, logic [DRAW_W-1:0] draw);
    int lim;
    lim = (m_limit > QDEPTH) ? QDEPTH : int'(m_limit);
    if (m_bo_active || m_radio == RADIO_TRANSMIT || m_sent_tick) begin
      if (m_qcount < lim) begin
        m_qstore[(m_qhead + m_qcount) % QDEPTH] = p;
        m_qcount++;
        return ACT_QUEUED;
      end
      return ACT_DROPPED;
    end
    if (m_radio == RADIO_IDLE) begin
      m_sent_tick = 1'b1;
      return ACT_SENT;
    end
    hold_packet(p, draw);
    return ACT_BACKOFF;
  endfunction

  function automatic out_item_t resolve_event(in_item_t ev);
    out_item_t r;
    action_e act;
    packet_t p;
    act = ACT_NONE;
    p = '0;
    case (ev.op)
      OP_UPPER: begin
        p = {ev.packet_tag, ev.dest_address};
        act = offer_packet(p, ev.backoff_draw);
      end
      OP_TICK: begin
        m_sent_tick = 1'b0;
        if (m_bo_active) begin
          if (m_bo_left <= 1) begin
            m_bo_active = 1'b0;
            m_bo_left = '0;
            p = m_held;
            act = offer_packet(p, ev.backoff_draw);
          end else begin
            m_bo_left--;
          end
        end
      end
      OP_RADIO: begin
        m_radio = radio_e'(ev.new_radio_state);
        if (m_radio == RADIO_IDLE && m_qcount > 0 && !m_bo_active) begin
          p = m_qstore[m_qhead];
          m_qhead = (m_qhead + 1) % QDEPTH;
          m_qcount--;
          hold_packet(p, ev.backoff_draw);
          act = ACT_BACKOFF;
        end
      end
      default: begin
        p = {ev.packet_tag, ev.dest_address};
        act = (ev.dest_address == m_station || ev.dest_address == BCAST_ADDR) ?
              ACT_UP : ACT_DISCARD;
      end
    endcase
    r.action = act;
    r.out_tag = p.tag;
    r.out_dest = p.dest;
    r.queued_count = COUNT_W'(m_qcount);
    r.backoff_pending = m_bo_active;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) mac_results_due.push_back(resolve_event(in_data));
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (events_to_send.size() != 0) begin
          in_data <= events_to_send.pop_front();
          in_valid <= 1'b1;
          gap_left = send_idle_on ? $urandom_range(0, 11) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (mac_results_due.size() == 0) begin
          if (n_errors < 10)
            $display("unexpected result: action=%0d tag=%h dest=%h count=%0d backoff=%0b",
                     out_data.action, out_data.out_tag, out_data.out_dest,
                     out_data.queued_count, out_data.backoff_pending);
          n_errors++;
        end else begin
          want = mac_results_due.pop_front();
          if (out_data.action !== want.action || out_data.out_tag !== want.out_tag ||
              out_data.out_dest !== want.out_dest ||
              out_data.queued_count !== want.queued_count ||
              out_data.backoff_pending !== want.backoff_pending) begin
            if (n_errors < 10)
              $display("transaction %0d: expected %0d/%h/%h/%0d/%0b, got %0d/%h/%h/%0d/%0b",
                       n_results, want.action, want.out_tag, want.out_dest,
                       want.queued_count, want.backoff_pending, out_data.action,
                       out_data.out_tag, out_data.out_dest, out_data.queued_count,
                       out_data.backoff_pending);
            n_errors++;
          end
        end
        n_results++;
        // hold off the output long enough for the block to back up
        if (n_results == 120 || n_results == 420) hold_left = HOLD_CYCLES;
        stall_left = recv_idle_on ? $urandom_range(0, 11) : 0;
      end else begin
        if (stall_left > 0) stall_left--;
        if (hold_left > 0) hold_left--;
      end
      out_stall <= (stall_left > 0) || (hold_left > 0);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic queue_event(op_e op, logic [TAG_W-1:0] tag, logic [ADDR_W-1:0] dest,
                             radio_e rs, logic [DRAW_W-1:0] draw);
    in_item_t ev;
    ev.op = op;
    ev.packet_tag = tag;
    ev.dest_address = dest;
    ev.new_radio_state = rs;
    ev.backoff_draw = draw;
    events_to_send.push_back(ev);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [ADDR_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_STATION_ADDR) m_station = value;
    else m_limit = value[COUNT_W-1:0];
    @(negedge clk);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (events_to_send.size() != 0 || in_valid || mac_results_due.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    logic [ADDR_W-1:0] station;
    logic [ADDR_W-1:0] dest;
    logic [DRAW_W-1:0] draw;
    logic [COUNT_W-1:0] limit;
    op_e op;
    radio_e rs;
    int sel;
    int k;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    station = {16'($urandom), 32'($urandom)};
    write_reg(CFG_STATION_ADDR, station);
    write_reg(CFG_QUEUE_LIMIT, ADDR_W'(2));

    queue_event(OP_UPPER, 16'h0000, '0, RADIO_IDLE, 4'd0);
    queue_event(OP_UPPER, 16'hffff, BCAST_ADDR, RADIO_SLEEP, 4'd15);
    queue_event(OP_UPPER, 16'($urandom), {16'($urandom), 32'($urandom)}, RADIO_IDLE, 4'd3);
    queue_event(OP_UPPER, 16'($urandom), {16'($urandom), 32'($urandom)}, RADIO_IDLE, 4'd3);
    queue_event(OP_TICK, '0, '0, RADIO_IDLE, 4'd0);
    queue_event(OP_RADIO, '0, '0, RADIO_RECEIVE, 4'd5);
    queue_event(OP_UPPER, 16'h1234, 48'h0123456789ab, RADIO_IDLE, 4'd0);
    queue_event(OP_UPPER, 16'h4321, 48'hba9876543210, RADIO_IDLE, 4'd0);
    queue_event(OP_TICK, '0, '0, RADIO_IDLE, 4'd1);
    queue_event(OP_TICK, '0, '0, RADIO_IDLE, 4'd2);
    queue_event(OP_TICK, '0, '0, RADIO_IDLE, 4'd7);
    queue_event(OP_RADIO, '0, '0, RADIO_TRANSMIT, 4'd0);
    queue_event(OP_TICK, '0, '0, RADIO_IDLE, 4'd4);
    queue_event(OP_RADIO, '0, '0, RADIO_IDLE, 4'd12);
    queue_event(OP_RADIO, '0, '0, RADIO_SLEEP, 4'd0);
    queue_event(OP_UPPER, 16'($urandom), {16'($urandom), 32'($urandom)}, RADIO_IDLE, 4'd10);
    queue_event(OP_RX, 16'($urandom), station, RADIO_IDLE, 4'd0);
    queue_event(OP_RX, 16'($urandom), BCAST_ADDR, RADIO_IDLE, 4'd0);
    queue_event(OP_RX, 16'($urandom), station ^ 48'h1, RADIO_IDLE, 4'd0);
    queue_event(OP_RX, 16'($urandom), station ^ (48'h1 << 47), RADIO_IDLE, 4'd0);
    queue_event(OP_RADIO, '0, '0, RADIO_IDLE, 4'd6);
    queue_event(OP_TICK, '0, '0, RADIO_IDLE, 4'd0);
    queue_event(OP_RX, 16'hffff, '0, RADIO_IDLE, 4'd0);
    wait_drained();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: limit = 4'd0;
        1: limit = 4'd15;
        2: limit = 4'd1;
        4: limit = 4'd3;
        default: limit = 4'd8;
      endcase
      if (ph == 0) station = '0;
      else if (ph == 1) station = BCAST_ADDR;
      else station = {16'($urandom), 32'($urandom)};
      write_reg(CFG_STATION_ADDR, station);
      write_reg(CFG_QUEUE_LIMIT, ADDR_W'(limit));
      send_idle_on = (ph % 3 != 1);
      recv_idle_on = (ph % 3 != 2);

      for (int i = 0; i < 88; i++) begin
        sel = $urandom_range(0, 99);
        dest = {16'($urandom), 32'($urandom)};
        draw = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(11, 15)) :
                                             4'($urandom_range(0, 10));
        k = $urandom_range(0, 99);
        rs = (k < 40) ? RADIO_IDLE : (k < 65) ? RADIO_RECEIVE :
             (k < 85) ? RADIO_TRANSMIT : RADIO_SLEEP;
        if (sel < 40) begin
          op = OP_UPPER;
        end else if (sel < 65) begin
          op = OP_TICK;
        end else if (sel < 83) begin
          op = OP_RADIO;
        end else begin
          op = OP_RX;
          case ($urandom_range(0, 3))
            0: dest = station;
            1: dest = BCAST_ADDR;
            2: dest = station ^ (48'h1 << $urandom_range(0, 47));
            default: ;
          endcase
        end
        queue_event(op, 16'($urandom), dest, rs, draw);
      end
      wait_drained();
    end

    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
